/* hw/rtl/pia_pkg.sv */
// Shared types and constants for the primitive index assembler.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package pia_pkg;

  localparam int unsigned IdxW       = 32;
  localparam int unsigned IndexWidth = 32;
  localparam logic [IdxW-1:0] IndexMask = IdxW'((64'd1 << IndexWidth) - 64'd1);

  localparam int unsigned TypeW      = 3;
  localparam int unsigned CfgAddrW   = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [CfgAddrW-3:0] REG_PRIM_TYPE = '0;

  typedef enum logic [TypeW-1:0] {
    PRIM_TRI_LIST  = 3'd0,
    PRIM_TRI_STRIP = 3'd1,
    PRIM_TRI_FAN   = 3'd2,
    PRIM_POINTS    = 3'd3,
    PRIM_LINE_LIST = 3'd4
  } prim_type_e;

  typedef struct packed {
    logic [IdxW-1:0] idx0;
    logic [IdxW-1:0] idx1;
    logic [IdxW-1:0] idx2;
    logic [1:0]      cnt;
  } prim_job_t;

endpackage

/* hw/rtl/pia_front.sv */
// Front end: type register, list state, classification of each index into a job.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pia_pkg::TypeW-1:0]         cfg_type_i,
  output logic [pia_pkg::TypeW-1:0]         type_o,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pia_pkg::IdxW-1:0]          vertex_index_i,
  input  logic                              list_last_i,
  input  logic                              full_i,
  output logic                              push_o,
  output pia_pkg::prim_job_t                job_o
);

  logic [pia_pkg::TypeW-1:0] type_q;
  logic [pia_pkg::IdxW-1:0]  first_q, first_d;
  logic [pia_pkg::IdxW-1:0]  older_q, older_d;
  logic [pia_pkg::IdxW-1:0]  newer_q, newer_d;
  logic [1:0]                pos_q, pos_d;
  logic                      par_q, par_d;
  logic [pia_pkg::IdxW-1:0]  v;
  logic                      accept;

  assign v          = vertex_index_i & pia_pkg::IndexMask;
  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign type_o     = type_q;
  assign push_o     = accept & (job_o.cnt != 2'd0);

  always_comb begin
    first_d = first_q;
    older_d = older_q;
    newer_d = newer_q;
    pos_d   = pos_q;
    par_d   = par_q;
    job_o   = '{idx0: v, idx1: v, idx2: v, cnt: 2'd0};
    case (type_q)
      pia_pkg::PRIM_TRI_STRIP: begin
        if (pos_q == 2'd0) begin
          older_d = v;
          pos_d   = 2'd1;
        end else if (pos_q == 2'd1) begin
          newer_d = v;
          pos_d   = 2'd2;
        end else begin
          job_o.idx0 = par_q ? newer_q : older_q;
          job_o.idx1 = par_q ? older_q : newer_q;
          job_o.cnt  = 2'd3;
          older_d    = newer_q;
          newer_d    = v;
          par_d      = ~par_q;
        end
      end
      pia_pkg::PRIM_TRI_FAN: begin
        if (pos_q == 2'd0) begin
          first_d = v;
          pos_d   = 2'd1;
        end else if (pos_q == 2'd1) begin
          newer_d = v;
          pos_d   = 2'd2;
        end else begin
          job_o.idx0 = first_q;
          job_o.idx1 = newer_q;
          job_o.cnt  = 2'd3;
          newer_d    = v;
        end
      end
      pia_pkg::PRIM_POINTS: begin
        job_o.cnt = 2'd1;
      end
      pia_pkg::PRIM_LINE_LIST: begin
        if (pos_q == 2'd0) begin
          older_d = v;
          pos_d   = 2'd1;
        end else begin
          job_o.idx0 = older_q;
          job_o.cnt  = 2'd2;
          pos_d      = 2'd0;
        end
      end
      default: begin
        if (pos_q == 2'd0) begin
          older_d = v;
          pos_d   = 2'd1;
        end else if (pos_q == 2'd1) begin
          newer_d = v;
          pos_d   = 2'd2;
        end else begin
          job_o.idx0 = older_q;
          job_o.idx1 = newer_q;
          job_o.cnt  = 2'd3;
          pos_d      = 2'd0;
        end
      end
    endcase
    if (list_last_i) begin
      first_d = '0;
      older_d = '0;
      newer_d = '0;
      pos_d   = 2'd0;
      par_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q  <= pia_pkg::PRIM_TRI_LIST;
      first_q <= '0;
      older_q <= '0;
      newer_q <= '0;
      pos_q   <= 2'd0;
      par_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        type_q <= cfg_type_i;
      end
      if (accept) begin
        first_q <= first_d;
        older_q <= older_d;
        newer_q <= newer_d;
        pos_q   <= pos_d;
        par_q   <= par_d;
      end
    end
  end

endmodule

/* hw/rtl/pia_queue.sv */
// Short job queue between front and back end.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pia_pkg::prim_job_t job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output pia_pkg::prim_job_t job_o
);

  pia_pkg::prim_job_t              mem_q [pia_pkg::QueueDepth];
  logic [pia_pkg::QPtrW-1:0]       wr_q;
  logic [pia_pkg::QPtrW-1:0]       rd_q;
  logic [pia_pkg::QCntW-1:0]       cnt_q;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = (cnt_q == pia_pkg::QCntW'(pia_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == pia_pkg::QPtrW'(pia_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == pia_pkg::QPtrW'(pia_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/pia_back.sv */
// Back end: takes jobs from the queue and sends them out one index per beat.
// Depends on pia_pkg.
`timescale 1ns / 1ps

module pia_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  pia_pkg::prim_job_t       job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [pia_pkg::IdxW-1:0] out_index_o,
  output logic                     primitive_end_o
);

  pia_pkg::prim_job_t job_q;
  logic [1:0]         beat_q;
  logic               busy_q;
  logic               last_beat;
  logic               out_acc;

  assign last_beat       = (beat_q == job_q.cnt - 2'd1);
  assign out_acc         = busy_q & out_ready_i;
  assign pop_o           = ~empty_i & (~busy_q | (out_acc & last_beat));
  assign out_valid_o     = busy_q;
  assign primitive_end_o = last_beat;

  always_comb begin
    case (beat_q)
      2'd0:    out_index_o = job_q.idx0;
      2'd1:    out_index_o = job_q.idx1;
      default: out_index_o = job_q.idx2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= 2'd0;
      busy_q <= 1'b0;
    end else begin
      if (pop_o) begin
        beat_q <= 2'd0;
        busy_q <= 1'b1;
      end else if (out_acc) begin
        if (last_beat) begin
          busy_q <= 1'b0;
        end
        beat_q <= beat_q + 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_beat_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (beat_q < job_q.cnt))
    else $error("beat beyond job length");

  a_no_empty_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (job_q.cnt != 2'd0))
    else $error("empty job in back end");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_beat && empty_i) |=> !busy_q)
    else $error("back end stays busy after final beat");

  a_next_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_beat) |=> (busy_q && beat_q == $past(beat_q) + 2'd1))
    else $error("beat did not advance");
`endif

endmodule

/* hw/rtl/primitive_index_assembler_core.sv */
// Path: the completing index of a primitive is written into the job queue, then
// loaded into the back end's job register, from which its indices leave. Throughput:
// one output beat per cycle while out_ready_i is high and jobs are queued; a job emits
// 3 indices for triangles, 2 for lines, 1 for points. A 2-job queue decouples input.
// Reset: asynchronous, clears type (triangle list), list state and queue.
`timescale 1ns / 1ps

module primitive_index_assembler_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pia_pkg::CfgAddrW-1:0] paddr,
  input  logic [pia_pkg::CfgDataW-1:0] pwdata,
  output logic [pia_pkg::CfgDataW-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  vertex_index_i,
  input  logic                         list_last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  out_index_o,
  output logic                         primitive_end_o
);

  logic                      cfg_we;
  logic                      reg_hit;
  logic [pia_pkg::TypeW-1:0] prim_type;
  logic                      push;
  logic                      pop;
  logic                      full;
  logic                      empty;
  pia_pkg::prim_job_t        push_job;
  pia_pkg::prim_job_t        head_job;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[pia_pkg::CfgAddrW-1:2] == pia_pkg::REG_PRIM_TYPE);
  assign cfg_we  = psel & penable & pwrite & reg_hit;
  assign prdata  = reg_hit ? pia_pkg::CfgDataW'(prim_type) : '0;

  pia_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_type_i     (pwdata[pia_pkg::TypeW-1:0]),
    .type_o         (prim_type),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vertex_index_i (vertex_index_i),
    .list_last_i    (list_last_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  pia_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  pia_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .job_i           (head_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_index_o     (out_index_o),
    .primitive_end_o (primitive_end_o)
  );

endmodule

/* tb/primitive_index_assembler_core_tb.sv */
// Self-checking testbench for primitive_index_assembler_core: directed table, then random lists
// under every primitive type, checked beat by beat against an in-bench index assembler.
// Depends on pia_pkg and the core RTL only.
`timescale 1ns / 1ps

module primitive_index_assembler_core_tb;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned TimeoutCycles = 400_000;
  localparam int unsigned DrainSlack    = 6;
  localparam int unsigned GapPct        = 27;
  localparam int unsigned NumPhases     = 14;
  localparam logic [pia_pkg::TypeW-1:0] TypeSpare5 = 3'd5;
  localparam logic [pia_pkg::TypeW-1:0] TypeSpare7 = 3'd7;
  localparam logic [pia_pkg::CfgAddrW-1:0] AddrPrimType = {pia_pkg::REG_PRIM_TYPE, 2'b00};

  typedef struct packed {
    logic [31:0] idx;
    logic        pend;
  } beat_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_chk_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [pia_pkg::TypeW-1:0]  ptype;
    logic [31:0]                vidx;
    logic                       last;
    row_chk_e                   chk;
    logic [31:0]                t_idx;
    logic                       t_end;
  } dir_row_t;

  localparam int unsigned NumDir = 34;
  localparam dir_row_t DirPlan [NumDir] = '{
    // reset type is triangle list
    '{ROW_ITEM, pia_pkg::PRIM_TRI_LIST,  32'h0000_0000, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_LIST,  32'h0000_0001, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_LIST,  32'hFFFF_FFFF, 1'b0, CHK_MODEL, 32'h0, 1'b0},
    // incomplete triangle dropped at end of list
    '{ROW_ITEM, pia_pkg::PRIM_TRI_LIST,  32'h0000_0005, 1'b1, CHK_NONE,  32'h0, 1'b0},
    '{ROW_CFG,  pia_pkg::PRIM_TRI_STRIP, 32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_STRIP, 32'h0000_000A, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_STRIP, 32'h0000_000B, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_STRIP, 32'h0000_000C, 1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_STRIP, 32'h0000_000D, 1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_STRIP, 32'h0000_000E, 1'b1, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_CFG,  pia_pkg::PRIM_TRI_FAN,   32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_FAN,   32'h0000_0014, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_FAN,   32'h0000_0015, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_FAN,   32'h0000_0016, 1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_TRI_FAN,   32'h0000_0017, 1'b1, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_CFG,  pia_pkg::PRIM_POINTS,    32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_POINTS,    32'hFFFF_FFFF, 1'b0, CHK_ONE, 32'hFFFF_FFFF, 1'b1},
    '{ROW_ITEM, pia_pkg::PRIM_POINTS,    32'h0000_0000, 1'b1, CHK_ONE, 32'h0000_0000, 1'b1},
    '{ROW_CFG,  pia_pkg::PRIM_LINE_LIST, 32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_LINE_LIST, 32'hAAAA_AAAA, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_LINE_LIST, 32'h5555_5555, 1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_LINE_LIST, 32'h0000_0007, 1'b1, CHK_NONE,  32'h0, 1'b0},
    // spare codes behave as triangle list
    '{ROW_CFG,  TypeSpare5,              32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, TypeSpare5,              32'h0000_0001, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, TypeSpare5,              32'h0000_0002, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, TypeSpare5,              32'h0000_0003, 1'b1, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_CFG,  TypeSpare7,              32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, TypeSpare7,              32'h0000_0004, 1'b0, CHK_NONE,  32'h0, 1'b0},
    '{ROW_ITEM, TypeSpare7,              32'h0000_0005, 1'b0, CHK_NONE,  32'h0, 1'b0},
    // type change mid list: line list sees held state
    '{ROW_CFG,  pia_pkg::PRIM_LINE_LIST, 32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_LINE_LIST, 32'h0000_0006, 1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_CFG,  pia_pkg::PRIM_POINTS,    32'h0,         1'b0, CHK_MODEL, 32'h0, 1'b0},
    '{ROW_ITEM, pia_pkg::PRIM_POINTS,    32'h0000_0008, 1'b0, CHK_ONE, 32'h0000_0008, 1'b1},
    '{ROW_ITEM, pia_pkg::PRIM_POINTS,    32'h8000_0000, 1'b0, CHK_ONE, 32'h8000_0000, 1'b1}
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pia_pkg::CfgAddrW-1:0] paddr;
  logic [pia_pkg::CfgDataW-1:0] pwdata;
  logic [pia_pkg::CfgDataW-1:0] prdata;
  logic                         pready;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [31:0]                  vertex_index_i;
  logic                         list_last_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [31:0]                  out_index_o;
  logic                         primitive_end_o;

  primitive_index_assembler_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .vertex_index_i (vertex_index_i),
    .list_last_i    (list_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_index_o    (out_index_o),
    .primitive_end_o(primitive_end_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // assembler state mirrored here
  logic [pia_pkg::TypeW-1:0] cur_type;
  logic [31:0]               fan_first;
  logic [31:0]               older_idx;
  logic [31:0]               newer_idx;
  logic [1:0]                held;
  logic                      odd_tri;

  beat_t       due_beats[$];
  beat_t       got_due;
  int unsigned err_cnt;
  logic        gaps_on;

  function automatic void add_beat(input beat_t b);
    due_beats.insert(due_beats.size(), b);
  endfunction

  function automatic void emit_tri(input logic [31:0] a, input logic [31:0] b,
                                   input logic [31:0] c);
    add_beat('{a, 1'b0});
    add_beat('{b, 1'b0});
    add_beat('{c, 1'b1});
  endfunction

  function automatic void clear_list();
    fan_first = '0;
    older_idx = '0;
    newer_idx = '0;
    held      = '0;
    odd_tri   = 1'b0;
  endfunction

  function automatic void assemble_index(input logic [31:0] raw, input logic last);
    logic [31:0] v;
    v = raw & pia_pkg::IndexMask;
    case (cur_type)
      pia_pkg::PRIM_TRI_STRIP: begin
        if (held == 2'd0) begin
          older_idx = v;
          held      = 2'd1;
        end else if (held == 2'd1) begin
          newer_idx = v;
          held      = 2'd2;
        end else begin
          if (!odd_tri) emit_tri(older_idx, newer_idx, v);
          else          emit_tri(newer_idx, older_idx, v);
          older_idx = newer_idx;
          newer_idx = v;
          odd_tri   = ~odd_tri;
        end
      end
      pia_pkg::PRIM_TRI_FAN: begin
        if (held == 2'd0) begin
          fan_first = v;
          held      = 2'd1;
        end else if (held == 2'd1) begin
          newer_idx = v;
          held      = 2'd2;
        end else begin
          emit_tri(fan_first, newer_idx, v);
          newer_idx = v;
        end
      end
      pia_pkg::PRIM_POINTS: add_beat('{v, 1'b1});
      pia_pkg::PRIM_LINE_LIST: begin
        if (held == 2'd0) begin
          older_idx = v;
          held      = 2'd1;
        end else begin
          add_beat('{older_idx, 1'b0});
          add_beat('{v, 1'b1});
          held = 2'd0;
        end
      end
      default: begin
        if (held == 2'd0) begin
          older_idx = v;
          held      = 2'd1;
        end else if (held == 2'd1) begin
          newer_idx = v;
          held      = 2'd2;
        end else begin
          emit_tri(older_idx, newer_idx, v);
          held = 2'd0;
        end
      end
    endcase
    if (last) clear_list();
  endfunction

  task automatic send_vertex(input logic [31:0] v, input logic last, input row_chk_e chk,
                             input beat_t typed);
    int unsigned before_n;
    while (gaps_on && $urandom_range(0, 99) < GapPct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    vertex_index_i <= v;
    list_last_i    <= last;
    do @(posedge clk_i); while (!in_ready_o);
    before_n = due_beats.size();
    assemble_index(v, last);
    if (chk != CHK_MODEL) begin
      while (due_beats.size() > before_n) void'(due_beats.pop_back());
      if (chk == CHK_ONE) add_beat(typed);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (DrainSlack) @(posedge clk_i);
  endtask

  task automatic write_type(input logic [pia_pkg::TypeW-1:0] t);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrPrimType;
    pwdata  <= pia_pkg::CfgDataW'(t);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    cur_type  = t;
  endtask

  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= !gaps_on || ($urandom_range(0, 99) >= GapPct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_beats.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, got idx=%h end=%b", $time,
                 out_index_o, primitive_end_o);
      end else begin
        got_due = due_beats.pop_front();
        if (out_index_o !== got_due.idx) begin
          err_cnt++;
          $display("%0t: out_index expected %h got %h", $time, got_due.idx, out_index_o);
        end
        if (primitive_end_o !== got_due.pend) begin
          err_cnt++;
          $display("%0t: primitive_end expected %b got %b", $time, got_due.pend,
                   primitive_end_o);
        end
      end
    end
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("primitive_index_assembler_core_tb: done, errors");
    $finish;
  end

  initial begin
    int unsigned left_n;
    int unsigned list_len;
    logic [pia_pkg::TypeW-1:0] ph_type;
    err_cnt        = 0;
    gaps_on        = 1'b1;
    cur_type       = pia_pkg::PRIM_TRI_LIST;
    clear_list();
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_valid_i     <= 1'b0;
    vertex_index_i <= '0;
    list_last_i    <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirPlan[i]) begin
      if (DirPlan[i].kind == ROW_CFG) begin
        drain();
        write_type(DirPlan[i].ptype);
      end else begin
        send_vertex(DirPlan[i].vidx, DirPlan[i].last, DirPlan[i].chk,
                    '{DirPlan[i].t_idx, DirPlan[i].t_end});
      end
    end

    // phases leave lists open at times, so the next type picks up held state
    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain();
      gaps_on = (p < 5 || p > 7);
      ph_type = pia_pkg::TypeW'((p * 3) % 8);
      write_type(ph_type);
      left_n = $urandom_range(8, 20);
      while (left_n != 0) begin
        list_len = $urandom_range(1, 9);
        for (int unsigned k = 0; k < list_len && left_n != 0; k++) begin
          left_n--;
          send_vertex(pick_index(), (k == list_len - 1) || ($urandom_range(0, 19) == 0),
                      CHK_MODEL, '0);
        end
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("primitive_index_assembler_core_tb: done, clean");
    end else begin
      $display("primitive_index_assembler_core_tb: done, errors");
    end
    $finish;
  end

endmodule
